[rtl/assert_macros.svh]
// Assertion macros used by the checker file of the rasteriser.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define ASSERT_ANY(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

[rtl/dbtr_pkg.sv]
// Shared constants, codes and the command word type of the depth-buffered rasteriser.
package dbtr_pkg;

   localparam int MaxWidth    = 512;
   localparam int MaxHeight   = 512;
   localparam int DepthBits   = 24;
   localparam int CoordBits   = 12;
   localparam int ReqDataBits = 240;
   localparam int RspDataBits = 72;

   localparam logic [1:0] ActClear = 2'd0;
   localparam logic [1:0] ActDraw  = 2'd1;
   localparam logic [1:0] ActRead  = 2'd2;

   localparam logic [1:0] RegFrameWidth  = 2'd0;
   localparam logic [1:0] RegFrameHeight = 2'd1;
   localparam logic [1:0] RegCullBack    = 2'd2;

   typedef struct packed {
      logic [1:0]           action;
      logic signed [16:0]   x0;
      logic signed [16:0]   y0;
      logic [23:0]          z0;
      logic signed [16:0]   x1;
      logic signed [16:0]   y1;
      logic [23:0]          z1;
      logic signed [16:0]   x2;
      logic signed [16:0]   y2;
      logic [23:0]          z2;
      logic [47:0]          shading;
      logic [17:0]          pixel_index;
      logic [CoordBits-1:0] bx0;
      logic [CoordBits-1:0] bx1;
      logic [CoordBits-1:0] by0;
      logic [CoordBits-1:0] by1;
      logic                 box_empty;
   } cmd_type;

endpackage

[rtl/dbtr_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
module dbtr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;
endmodule

[rtl/dbtr_fifo.sv]
// Small command queue between the front and the back of the rasteriser.
module dbtr_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             full,
   output logic             empty
);
   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PW-1:0]    wptr_ff, wptr_in, rptr_ff, rptr_in;
   logic [PW:0]      count_ff, count_in;

   always_comb begin
      wptr_in  = wptr_ff;
      rptr_in  = rptr_ff;
      count_in = count_ff;
      if (push) begin
         wptr_in = (wptr_ff == PW'(DEPTH - 1)) ? '0 : wptr_ff + 1'b1;
      end
      if (pop) begin
         rptr_in = (rptr_ff == PW'(DEPTH - 1)) ? '0 : rptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
      if (push) begin
         slot_ff[wptr_ff] <= push_data;
      end
   end

   assign pop_data = slot_ff[rptr_ff];
   assign full     = (count_ff == (PW + 1)'(DEPTH));
   assign empty    = (count_ff == '0);
endmodule

[rtl/dbtr_front.sv]
// Front end: register port, word intake and bounding-box clipping.
module dbtr_front #(
   parameter int MAX_WIDTH  = dbtr_pkg::MaxWidth,
   parameter int MAX_HEIGHT = dbtr_pkg::MaxHeight
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [dbtr_pkg::ReqDataBits-1:0] req_tdata,
   input  logic [1:0]                       req_tuser,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [3:0]                       csr_paddr,
   input  logic [31:0]                      csr_pwdata,
   output logic [31:0]                      csr_prdata,
   output logic                             csr_pready,
   input  logic                             init_busy,
   input  logic                             queue_full,
   output logic                             push,
   output dbtr_pkg::cmd_type                cmd,
   output logic                             cull
);
   import dbtr_pkg::*;

   logic [9:0]         fw_ff, fw_in, fh_ff, fh_in;
   logic               cull_ff, cull_in;
   logic [13:0]        act_w, act_h;
   logic signed [18:0] lim_x, lim_y;
   logic signed [16:0] mnx, mxx, mny, mxy;
   logic signed [18:0] lo_x, hi_x, lo_y, hi_y, bx0c, bx1c, by0c, by1c;
   logic               wr;

   assign wr = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      fw_in   = fw_ff;
      fh_in   = fh_ff;
      cull_in = cull_ff;
      if (wr) begin
         case (csr_paddr[3:2])
            RegFrameWidth:  fw_in   = csr_pwdata[9:0];
            RegFrameHeight: fh_in   = csr_pwdata[9:0];
            RegCullBack:    cull_in = csr_pwdata[0];
            default:        ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fw_ff   <= 10'd512;
         fh_ff   <= 10'd512;
         cull_ff <= 1'b1;
      end else begin
         fw_ff   <= fw_in;
         fh_ff   <= fh_in;
         cull_ff <= cull_in;
      end
   end

   always_comb begin
      case (csr_paddr[3:2])
         RegFrameWidth:  csr_prdata = {22'd0, fw_ff};
         RegFrameHeight: csr_prdata = {22'd0, fh_ff};
         RegCullBack:    csr_prdata = {31'd0, cull_ff};
         default:        csr_prdata = 32'd0;
      endcase
   end

   assign csr_pready = 1'b1;
   assign cull       = cull_ff;

   always_comb begin
      cmd.action      = req_tuser;
      cmd.x0          = req_tdata[16:0];
      cmd.y0          = req_tdata[33:17];
      cmd.z0          = req_tdata[57:34];
      cmd.x1          = req_tdata[74:58];
      cmd.y1          = req_tdata[91:75];
      cmd.z1          = req_tdata[115:92];
      cmd.x2          = req_tdata[132:116];
      cmd.y2          = req_tdata[149:133];
      cmd.z2          = req_tdata[173:150];
      cmd.shading     = req_tdata[221:174];
      cmd.pixel_index = req_tdata[239:222];

      act_w = ({4'd0, fw_ff} < 14'(MAX_WIDTH))  ? {4'd0, fw_ff} : 14'(MAX_WIDTH);
      act_h = ({4'd0, fh_ff} < 14'(MAX_HEIGHT)) ? {4'd0, fh_ff} : 14'(MAX_HEIGHT);
      lim_x = $signed({5'd0, act_w}) - 19'sd1;
      lim_y = $signed({5'd0, act_h}) - 19'sd1;

      mnx = (cmd.x0 < cmd.x1) ? cmd.x0 : cmd.x1;
      mnx = (mnx < cmd.x2) ? mnx : cmd.x2;
      mxx = (cmd.x0 > cmd.x1) ? cmd.x0 : cmd.x1;
      mxx = (mxx > cmd.x2) ? mxx : cmd.x2;
      mny = (cmd.y0 < cmd.y1) ? cmd.y0 : cmd.y1;
      mny = (mny < cmd.y2) ? mny : cmd.y2;
      mxy = (cmd.y0 > cmd.y1) ? cmd.y0 : cmd.y1;
      mxy = (mxy > cmd.y2) ? mxy : cmd.y2;

      lo_x = $signed({{2{mnx[16]}}, mnx}) >>> 4;
      hi_x = ($signed({{2{mxx[16]}}, mxx}) + 19'sd15) >>> 4;
      lo_y = $signed({{2{mny[16]}}, mny}) >>> 4;
      hi_y = ($signed({{2{mxy[16]}}, mxy}) + 19'sd15) >>> 4;

      bx0c = (lo_x < 19'sd0) ? 19'sd0 : lo_x;
      by0c = (lo_y < 19'sd0) ? 19'sd0 : lo_y;
      bx1c = (hi_x > lim_x) ? lim_x : hi_x;
      by1c = (hi_y > lim_y) ? lim_y : hi_y;

      cmd.bx0       = bx0c[CoordBits-1:0];
      cmd.bx1       = bx1c[CoordBits-1:0];
      cmd.by0       = by0c[CoordBits-1:0];
      cmd.by1       = by1c[CoordBits-1:0];
      cmd.box_empty = (bx1c < bx0c) || (by1c < by0c);
   end

   assign req_tready = !queue_full && !init_busy;
   assign push       = req_tvalid && req_tready;
endmodule

[rtl/dbtr_back.sv]
// Back end: clear sweep, triangle setup, pixel walk, depth test, shading and read-back.
module dbtr_back #(
   parameter int MAX_WIDTH  = dbtr_pkg::MaxWidth,
   parameter int MAX_HEIGHT = dbtr_pkg::MaxHeight,
   parameter int DEPTH_BITS = dbtr_pkg::DepthBits
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             queue_empty,
   input  dbtr_pkg::cmd_type                queue_cmd,
   output logic                             pop,
   input  logic                             cull,
   output logic                             init_busy,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [dbtr_pkg::RspDataBits-1:0] rsp_tdata
);
   import dbtr_pkg::*;

   localparam int Store = MAX_WIDTH * MAX_HEIGHT;
   localparam int AW    = $clog2(Store);
   localparam int DB    = DEPTH_BITS;
   localparam int WW    = DB + 25;
   localparam int IW    = ((AW > 18) ? AW : 18) + 1;
   localparam int EW    = 40;
   localparam int UW    = 37;
   localparam int ZW    = 62;
   localparam int LW    = 46;
   localparam int NW    = 56;
   localparam logic [DB-1:0] Far = '1;

   localparam logic [4:0] StInit   = 5'd0;
   localparam logic [4:0] StIdle   = 5'd1;
   localparam logic [4:0] StClear  = 5'd2;
   localparam logic [4:0] StRead   = 5'd3;
   localparam logic [4:0] StRdWait = 5'd4;
   localparam logic [4:0] StSetup  = 5'd5;
   localparam logic [4:0] StCheck  = 5'd6;
   localparam logic [4:0] StPix    = 5'd7;
   localparam logic [4:0] StZMul   = 5'd8;
   localparam logic [4:0] StZDiv   = 5'd9;
   localparam logic [4:0] StZTest  = 5'd10;
   localparam logic [4:0] StCMul   = 5'd11;
   localparam logic [4:0] StCDiv   = 5'd12;
   localparam logic [4:0] StWrite  = 5'd13;
   localparam logic [4:0] StNext   = 5'd14;
   localparam logic [4:0] StResult = 5'd15;

   function automatic logic [DB-1:0] depth_in(input logic [23:0] q);
      logic [63:0] t;
      t = {40'd0, q} << 8;
      t = t >> (32 - DB);
      return t[DB-1:0];
   endfunction

   function automatic logic [23:0] depth_out(input logic [DB-1:0] d);
      logic [63:0] t;
      t = 64'(d) << 32;
      t = t >> (DB + 8);
      return t[23:0];
   endfunction

   logic [4:0]           state_ff, state_in, step_ff, step_in;
   logic [1:0]           ch_ff, ch_in;
   cmd_type              cmd_ff, cmd_in;
   logic signed [EW-1:0] det_ff, det_in, ea_ff, ea_in, eb_ff, eb_in;
   logic signed [EW-1:0] row_ea_ff, row_ea_in, row_eb_ff, row_eb_in;
   logic signed [EW-1:0] sxa_ff, sxa_in, sya_ff, sya_in, sxb_ff, sxb_in, syb_ff, syb_in;
   logic [NW-1:0]        d255_ff, d255_in, num_ff, num_in;
   logic [UW-1:0]        ua_ff, ua_in, ub_ff, ub_in, uc_ff, uc_in;
   logic [ZW-1:0]        zacc_ff, zacc_in;
   logic [LW-1:0]        lacc_ff, lacc_in;
   logic [23:0]          q_ff, q_in, rgb_ff, rgb_in, color_ff, color_in;
   logic [23:0]          depth_ff, depth_in_r;
   logic [DB-1:0]        znew_ff, znew_in;
   logic [CoordBits-1:0] px_ff, px_in, py_ff, py_in;
   logic [AW-1:0]        row_base_ff, row_base_in, addr_ff, addr_in, pix_addr;
   logic [18:0]          frag_ff, frag_in;
   logic                 status_ff, status_in, cov_ff, cov_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [RspDataBits-1:0] rsp_data_ff, rsp_data_in;

   logic                 ram_we, ram_re;
   logic [AW-1:0]        ram_waddr, ram_raddr;
   logic [WW-1:0]        ram_wdata, ram_rdata;

   logic signed [17:0]   dx02, dy12, dx12, dy02, dx21, dy20;
   logic signed [18:0]   cx0, cy0, mop_a, mop_b;
   logic signed [37:0]   mprod;
   logic signed [EW-1:0] mext, ec;
   logic [7:0]           l0, l1, l2, base;
   logic [ZW-1:0]        zsel, zcmp;
   logic [LW-1:0]        lsel;
   logic [NW-1:0]        ccmp;
   logic [IW-1:0]        pidx;
   logic                 out_free;

   dbtr_ram #(.WIDTH(WW), .DEPTH(Store)) u_store (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   assign dx02 = 18'(cmd_ff.x0) - 18'(cmd_ff.x2);
   assign dy12 = 18'(cmd_ff.y1) - 18'(cmd_ff.y2);
   assign dx12 = 18'(cmd_ff.x1) - 18'(cmd_ff.x2);
   assign dy02 = 18'(cmd_ff.y0) - 18'(cmd_ff.y2);
   assign dx21 = 18'(cmd_ff.x2) - 18'(cmd_ff.x1);
   assign dy20 = 18'(cmd_ff.y2) - 18'(cmd_ff.y0);
   assign cx0  = $signed({3'd0, cmd_ff.bx0, 4'b1000}) - 19'(cmd_ff.x2);
   assign cy0  = $signed({3'd0, cmd_ff.by0, 4'b1000}) - 19'(cmd_ff.y2);
   assign l0   = cmd_ff.shading[23:16];
   assign l1   = cmd_ff.shading[15:8];
   assign l2   = cmd_ff.shading[7:0];
   assign pidx = IW'(cmd_ff.pixel_index);
   assign ec   = det_ff - ea_ff - eb_ff;
   assign pix_addr = row_base_ff + AW'(px_ff);
   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      case (step_ff[2:0])
         3'd0:    begin mop_a = 19'(dx02); mop_b = 19'(dy12); end
         3'd1:    begin mop_a = 19'(dx12); mop_b = 19'(dy02); end
         3'd2:    begin mop_a = 19'(dy12); mop_b = cx0;       end
         3'd3:    begin mop_a = 19'(dx21); mop_b = cy0;       end
         3'd4:    begin mop_a = 19'(dy20); mop_b = cx0;       end
         default: begin mop_a = 19'(dx02); mop_b = cy0;       end
      endcase
      mprod = mop_a * mop_b;
      mext  = EW'(mprod);
   end

   always_comb begin
      case (ch_ff)
         2'd0:    base = cmd_ff.shading[47:40];
         2'd1:    base = cmd_ff.shading[39:32];
         default: base = cmd_ff.shading[31:24];
      endcase
      zsel = (cmd_ff.z0[step_ff] ? ZW'(ua_ff) : '0) + (cmd_ff.z1[step_ff] ? ZW'(ub_ff) : '0)
           + (cmd_ff.z2[step_ff] ? ZW'(uc_ff) : '0);
      lsel = (l0[step_ff[2:0]] ? LW'(ua_ff) : '0) + (l1[step_ff[2:0]] ? LW'(ub_ff) : '0)
           + (l2[step_ff[2:0]] ? LW'(uc_ff) : '0);
      zcmp = ZW'($unsigned(det_ff)) << step_ff;
      ccmp = d255_ff << step_ff;
   end

   always_comb begin
      state_in    = state_ff;
      step_in     = step_ff;
      ch_in       = ch_ff;
      cmd_in      = cmd_ff;
      det_in      = det_ff;
      ea_in       = ea_ff;
      eb_in       = eb_ff;
      row_ea_in   = row_ea_ff;
      row_eb_in   = row_eb_ff;
      sxa_in      = sxa_ff;
      sya_in      = sya_ff;
      sxb_in      = sxb_ff;
      syb_in      = syb_ff;
      d255_in     = d255_ff;
      num_in      = num_ff;
      ua_in       = ua_ff;
      ub_in       = ub_ff;
      uc_in       = uc_ff;
      zacc_in     = zacc_ff;
      lacc_in     = lacc_ff;
      q_in        = q_ff;
      rgb_in      = rgb_ff;
      znew_in     = znew_ff;
      px_in       = px_ff;
      py_in       = py_ff;
      row_base_in = row_base_ff;
      addr_in     = addr_ff;
      frag_in     = frag_ff;
      status_in   = status_ff;
      color_in    = color_ff;
      cov_in      = cov_ff;
      depth_in_r  = depth_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      pop       = 1'b0;
      ram_we    = 1'b0;
      ram_re    = 1'b0;
      ram_waddr = addr_ff;
      ram_raddr = pix_addr;
      ram_wdata = {1'b0, 24'd0, Far};

      case (state_ff)
         StInit, StClear: begin
            ram_we = 1'b1;
            if (addr_ff == AW'(Store - 1)) begin
               addr_in  = '0;
               state_in = (state_ff == StInit) ? StIdle : StResult;
            end else begin
               addr_in = addr_ff + 1'b1;
            end
         end
         StIdle: begin
            if (!queue_empty) begin
               pop        = 1'b1;
               cmd_in     = queue_cmd;
               status_in  = 1'b0;
               frag_in    = '0;
               color_in   = '0;
               cov_in     = 1'b0;
               depth_in_r = '0;
               step_in    = '0;
               addr_in    = '0;
               case (queue_cmd.action)
                  ActClear: state_in = StClear;
                  ActDraw:  state_in = StSetup;
                  ActRead:  state_in = StRead;
                  default:  state_in = StResult;
               endcase
            end
         end
         StRead: begin
            ram_re    = 1'b1;
            ram_raddr = pidx[AW-1:0];
            state_in  = StRdWait;
         end
         StRdWait: begin
            if (pidx < IW'(Store)) begin
               color_in   = ram_rdata[WW-2:DB];
               cov_in     = ram_rdata[WW-1];
               depth_in_r = depth_out(ram_rdata[DB-1:0]);
            end else begin
               depth_in_r = depth_out(Far);
            end
            state_in = StResult;
         end
         StSetup: begin
            case (step_ff[2:0])
               3'd0:    det_in = mext;
               3'd1:    det_in = det_ff - mext;
               3'd2:    ea_in  = mext;
               3'd3:    ea_in  = ea_ff + mext;
               3'd4:    eb_in  = mext;
               default: eb_in  = eb_ff + mext;
            endcase
            if (step_ff == 5'd5) begin
               state_in = StCheck;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         StCheck: begin
            if (det_ff == '0 || (cull && det_ff < 0) || cmd_ff.box_empty) begin
               status_in = 1'b1;
               state_in  = StResult;
            end else begin
               if (det_ff < 0) begin
                  det_in    = -det_ff;
                  ea_in     = -ea_ff;
                  eb_in     = -eb_ff;
                  row_ea_in = -ea_ff;
                  row_eb_in = -eb_ff;
                  sxa_in    = -(EW'(dy12) <<< 4);
                  sya_in    = -(EW'(dx21) <<< 4);
                  sxb_in    = -(EW'(dy20) <<< 4);
                  syb_in    = -(EW'(dx02) <<< 4);
                  d255_in   = (NW'($unsigned(-det_ff)) << 8) - NW'($unsigned(-det_ff));
               end else begin
                  row_ea_in = ea_ff;
                  row_eb_in = eb_ff;
                  sxa_in    = EW'(dy12) <<< 4;
                  sya_in    = EW'(dx21) <<< 4;
                  sxb_in    = EW'(dy20) <<< 4;
                  syb_in    = EW'(dx02) <<< 4;
                  d255_in   = (NW'($unsigned(det_ff)) << 8) - NW'($unsigned(det_ff));
               end
               px_in       = cmd_ff.bx0;
               py_in       = cmd_ff.by0;
               row_base_in = AW'(AW'(cmd_ff.by0) * AW'(MAX_WIDTH));
               state_in    = StPix;
            end
         end
         StPix: begin
            if (ea_ff >= 0 && eb_ff >= 0 && ec >= 0) begin
               ram_re   = 1'b1;
               addr_in  = pix_addr;
               ua_in    = ea_ff[UW-1:0];
               ub_in    = eb_ff[UW-1:0];
               uc_in    = ec[UW-1:0];
               zacc_in  = '0;
               lacc_in  = '0;
               step_in  = 5'd23;
               state_in = StZMul;
            end else begin
               state_in = StNext;
            end
         end
         StZMul: begin
            zacc_in = (zacc_ff << 1) + zsel;
            if (step_ff < 5'd8) begin
               lacc_in = (lacc_ff << 1) + lsel;
            end
            if (step_ff == '0) begin
               step_in  = 5'd23;
               q_in     = '0;
               state_in = StZDiv;
            end else begin
               step_in = step_ff - 1'b1;
            end
         end
         StZDiv: begin
            if (zacc_ff >= zcmp) begin
               zacc_in = zacc_ff - zcmp;
               q_in    = {q_ff[22:0], 1'b1};
            end else begin
               q_in    = {q_ff[22:0], 1'b0};
            end
            if (step_ff == '0) begin
               state_in = StZTest;
            end else begin
               step_in = step_ff - 1'b1;
            end
         end
         StZTest: begin
            znew_in = depth_in(q_ff);
            if (depth_in(q_ff) >= ram_rdata[DB-1:0]) begin
               state_in = StNext;
            end else begin
               ch_in    = '0;
               state_in = StCMul;
            end
         end
         StCMul: begin
            num_in   = NW'(base) * NW'(lacc_ff);
            step_in  = 5'd7;
            q_in     = '0;
            state_in = StCDiv;
         end
         StCDiv: begin
            if (num_ff >= ccmp) begin
               num_in = num_ff - ccmp;
               q_in   = {q_ff[22:0], 1'b1};
            end else begin
               q_in   = {q_ff[22:0], 1'b0};
            end
            if (step_ff == '0) begin
               rgb_in = {rgb_ff[15:0], q_in[7:0]};
               if (ch_ff == 2'd2) begin
                  state_in = StWrite;
               end else begin
                  ch_in    = ch_ff + 1'b1;
                  state_in = StCMul;
               end
            end else begin
               step_in = step_ff - 1'b1;
            end
         end
         StWrite: begin
            ram_we    = 1'b1;
            ram_wdata = {1'b1, rgb_ff, znew_ff};
            if (frag_ff != '1) begin
               frag_in = frag_ff + 1'b1;
            end
            state_in = StNext;
         end
         StNext: begin
            if (px_ff == cmd_ff.bx1) begin
               if (py_ff == cmd_ff.by1) begin
                  state_in = StResult;
               end else begin
                  py_in       = py_ff + 1'b1;
                  px_in       = cmd_ff.bx0;
                  row_base_in = row_base_ff + AW'(MAX_WIDTH);
                  row_ea_in   = row_ea_ff + sya_ff;
                  row_eb_in   = row_eb_ff + syb_ff;
                  ea_in       = row_ea_ff + sya_ff;
                  eb_in       = row_eb_ff + syb_ff;
                  state_in    = StPix;
               end
            end else begin
               px_in    = px_ff + 1'b1;
               ea_in    = ea_ff + sxa_ff;
               eb_in    = eb_ff + sxb_ff;
               state_in = StPix;
            end
         end
         StResult: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {3'd0, depth_ff, cov_ff, color_ff, frag_ff, status_ff};
               state_in     = StIdle;
            end
         end
         default: state_in = StIdle;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= StInit;
         addr_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         addr_ff      <= addr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      step_ff     <= step_in;
      ch_ff       <= ch_in;
      cmd_ff      <= cmd_in;
      det_ff      <= det_in;
      ea_ff       <= ea_in;
      eb_ff       <= eb_in;
      row_ea_ff   <= row_ea_in;
      row_eb_ff   <= row_eb_in;
      sxa_ff      <= sxa_in;
      sya_ff      <= sya_in;
      sxb_ff      <= sxb_in;
      syb_ff      <= syb_in;
      d255_ff     <= d255_in;
      num_ff      <= num_in;
      ua_ff       <= ua_in;
      ub_ff       <= ub_in;
      uc_ff       <= uc_in;
      zacc_ff     <= zacc_in;
      lacc_ff     <= lacc_in;
      q_ff        <= q_in;
      rgb_ff      <= rgb_in;
      znew_ff     <= znew_in;
      px_ff       <= px_in;
      py_ff       <= py_in;
      row_base_ff <= row_base_in;
      frag_ff     <= frag_in;
      status_ff   <= status_in;
      color_ff    <= color_in;
      cov_ff      <= cov_in;
      depth_ff    <= depth_in_r;
      rsp_data_ff <= rsp_data_in;
   end

   assign init_busy  = (state_ff == StInit);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
endmodule

[rtl/depth_buffer_triangle_rasterizer_unit.sv]
// Top level of the depth-buffered triangle rasteriser.
//  Channel   Direction  Ports         Contents
//  request   in         req_*         one command word per action
//  response  out        rsp_*         one result word per command
//  control   in/out     csr_*         frame width, frame height, back-face culling
// After reset the store is swept with req_tready low.
// A draw runs a serial setup and then walks the box pixels; a pixel inside the triangle
// goes through the serial depth multiply and divide and the depth test, and a written
// one also through the three colour divides.
// Up to two commands queue while one executes; a held result word stalls the back end only.
module depth_buffer_triangle_rasterizer_unit #(
   parameter int MAX_WIDTH  = dbtr_pkg::MaxWidth,
   parameter int MAX_HEIGHT = dbtr_pkg::MaxHeight,
   parameter int DEPTH_BITS = dbtr_pkg::DepthBits
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // v0_x, v0_y, v0_z, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z, shading, pixel_index
   input  logic [dbtr_pkg::ReqDataBits-1:0] req_tdata,
   // action
   input  logic [1:0]                       req_tuser,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // status, fragments_written, pixel_color, pixel_covered, pixel_depth, zero pad
   output logic [dbtr_pkg::RspDataBits-1:0] rsp_tdata,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [3:0]                       csr_paddr,
   input  logic [31:0]                      csr_pwdata,
   output logic [31:0]                      csr_prdata,
   output logic                             csr_pready
);
   import dbtr_pkg::*;

   cmd_type               push_cmd, pop_cmd;
   logic [$bits(cmd_type)-1:0] pop_bits;
   logic                  push, pop, queue_full, queue_empty, init_busy, cull;

   dbtr_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .init_busy   (init_busy),
      .queue_full  (queue_full),
      .push        (push),
      .cmd         (push_cmd),
      .cull        (cull)
   );

   dbtr_fifo #(.WIDTH($bits(cmd_type)), .DEPTH(2)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_cmd),
      .pop       (pop),
      .pop_data  (pop_bits),
      .full      (queue_full),
      .empty     (queue_empty)
   );

   assign pop_cmd = cmd_type'(pop_bits);

   dbtr_back #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT),
      .DEPTH_BITS (DEPTH_BITS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .queue_empty (queue_empty),
      .queue_cmd   (pop_cmd),
      .pop         (pop),
      .cull        (cull),
      .init_busy   (init_busy),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata)
   );
endmodule

[rtl/dbtr_checker.sv]
// Port-level checker for the rasteriser and its bind to the top level.
`include "assert_macros.svh"

module dbtr_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [71:0] rsp_tdata
);
   `ASSERT_ANY(a_sweep_blocks_intake, reset |=> !req_tready, "intake open during store sweep")
   `ASSERT_CLK(a_rsp_hold, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata), "stalled result word changed")
   `ASSERT_CLK(a_reject_clean, rsp_tvalid && rsp_tdata[0] |-> rsp_tdata[68:1] == 68'd0, "rejected draw carries data")
   `ASSERT_CLK(a_covered_near, rsp_tvalid && rsp_tdata[44] |-> rsp_tdata[68:45] != 24'hFFFFFF, "covered pixel at far depth")
endmodule

bind depth_buffer_triangle_rasterizer_unit dbtr_checker u_dbtr_checker (.*);

[bench/dbtr_scoreboard.sv]
// Scoreboard of the rasteriser: watches all three ports, predicts each result word and compares.
module dbtr_scoreboard (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   input  logic                             req_tready,
   input  logic [dbtr_pkg::ReqDataBits-1:0] req_tdata,
   input  logic [1:0]                       req_tuser,
   input  logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   input  logic [dbtr_pkg::RspDataBits-1:0] rsp_tdata,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [3:0]                       csr_paddr,
   input  logic [31:0]                      csr_pwdata,
   input  logic                             csr_pready,
   output int                               pending,
   output int                               errors
);
   import dbtr_pkg::*;

   localparam int StoreSize = MaxWidth * MaxHeight;
   localparam logic [23:0] FarDepth = 24'hFFFFFF;

   typedef struct packed {
      logic        status;
      logic [18:0] frags;
      logic [23:0] color;
      logic        covered;
      logic [23:0] depth;
   } result_type;

   logic [23:0] depth_mem [StoreSize];
   logic [24:0] color_mem [StoreSize];
   logic [9:0]  frame_w;
   logic [9:0]  frame_h;
   logic        cull_on;
   result_type  expected_q[$];

   assign pending = expected_q.size();

   function automatic longint fl16(longint v);
      return v >>> 4;
   endfunction

   function automatic longint sx(logic [16:0] v);
      return longint'($signed(v));
   endfunction

   function automatic void wipe_frame();
      for (int i = 0; i < StoreSize; i++) begin
         depth_mem[i] = FarDepth;
         color_mem[i] = '0;
      end
   endfunction

   function automatic void rasterise(input logic [239:0] d, output logic rejected,
                                     output logic [18:0] count);
      longint x0, y0, x1, y1, x2, y2, det, sgn, bx0, bx1, by0, by1, w, h, cx, cy, ea, eb, ec;
      longint unsigned z0, z1, z2, l0, l1, l2, r, g, b, zsum, lsum, dv;
      logic [23:0] z;
      int idx;
      x0 = sx(d[16:0]);    y0 = sx(d[33:17]);   z0 = d[57:34];
      x1 = sx(d[74:58]);   y1 = sx(d[91:75]);   z1 = d[115:92];
      x2 = sx(d[132:116]); y2 = sx(d[149:133]); z2 = d[173:150];
      r = d[221:214]; g = d[213:206]; b = d[205:198];
      l0 = d[197:190]; l1 = d[189:182]; l2 = d[181:174];
      count = '0;
      rejected = 1'b1;
      det = (x0 - x2) * (y1 - y2) - (x1 - x2) * (y0 - y2);
      if (det == 0 || (cull_on && det < 0)) return;
      sgn = det < 0 ? -1 : 1;
      det = det * sgn;
      w = frame_w < MaxWidth ? frame_w : MaxWidth;
      h = frame_h < MaxHeight ? frame_h : MaxHeight;
      bx0 = fl16(x0 < x1 ? (x0 < x2 ? x0 : x2) : (x1 < x2 ? x1 : x2));
      by0 = fl16(y0 < y1 ? (y0 < y2 ? y0 : y2) : (y1 < y2 ? y1 : y2));
      bx1 = -fl16(-(x0 > x1 ? (x0 > x2 ? x0 : x2) : (x1 > x2 ? x1 : x2)));
      by1 = -fl16(-(y0 > y1 ? (y0 > y2 ? y0 : y2) : (y1 > y2 ? y1 : y2)));
      if (bx0 < 0) bx0 = 0;
      if (by0 < 0) by0 = 0;
      if (bx1 > w - 1) bx1 = w - 1;
      if (by1 > h - 1) by1 = h - 1;
      if (bx1 < bx0 || by1 < by0) return;
      rejected = 1'b0;
      for (longint py = by0; py <= by1; py++) begin
         cy = 16 * py + 8 - y2;
         for (longint px = bx0; px <= bx1; px++) begin
            cx = 16 * px + 8 - x2;
            ea = sgn * ((y1 - y2) * cx + (x2 - x1) * cy);
            eb = sgn * ((y2 - y0) * cx + (x0 - x2) * cy);
            ec = det - ea - eb;
            if (ea < 0 || eb < 0 || ec < 0) continue;
            zsum = ea * z0 + eb * z1 + ec * z2;
            z = 24'(zsum / det);
            idx = int'(py * MaxWidth + px);
            if (z >= depth_mem[idx]) continue;
            depth_mem[idx] = z;
            lsum = ea * l0 + eb * l1 + ec * l2;
            dv = 255 * det;
            color_mem[idx] = {1'b1, 8'((r * lsum) / dv), 8'((g * lsum) / dv),
                              8'((b * lsum) / dv)};
            if (count != 19'h7FFFF) count++;
         end
      end
   endfunction

   always @(posedge clock) begin
      result_type exp_r, got;
      logic rej;
      logic [18:0] n;
      if (reset) begin
         expected_q.delete();
         errors <= 0;
         frame_w = 10'd512;
         frame_h = 10'd512;
         cull_on = 1'b1;
         wipe_frame();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            if (csr_paddr == {RegFrameWidth, 2'b00}) frame_w = csr_pwdata[9:0];
            else if (csr_paddr == {RegFrameHeight, 2'b00}) frame_h = csr_pwdata[9:0];
            else if (csr_paddr == {RegCullBack, 2'b00}) cull_on = csr_pwdata[0];
         end
         if (rsp_tvalid && rsp_tready) begin
            got = '{rsp_tdata[0], rsp_tdata[19:1], rsp_tdata[43:20], rsp_tdata[44],
                    rsp_tdata[68:45]};
            if (expected_q.size() == 0) begin
               $display("%0t: unexpected result word %h", $time, rsp_tdata);
               errors <= errors + 1;
            end else begin
               exp_r = expected_q.pop_front();
               if (got != exp_r) begin
                  if (got.status != exp_r.status)
                     $display("%0t: status expected %0d actual %0d", $time, exp_r.status,
                              got.status);
                  if (got.frags != exp_r.frags)
                     $display("%0t: fragments expected %0d actual %0d", $time, exp_r.frags,
                              got.frags);
                  if (got.color != exp_r.color)
                     $display("%0t: colour expected %h actual %h", $time, exp_r.color,
                              got.color);
                  if (got.covered != exp_r.covered)
                     $display("%0t: covered expected %0d actual %0d", $time, exp_r.covered,
                              got.covered);
                  if (got.depth != exp_r.depth)
                     $display("%0t: depth expected %h actual %h", $time, exp_r.depth,
                              got.depth);
                  errors <= errors + 1;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            exp_r = '0;
            case (req_tuser)
               ActClear: wipe_frame();
               ActDraw: begin
                  rasterise(req_tdata, rej, n);
                  exp_r.status = rej;
                  exp_r.frags = rej ? '0 : n;
               end
               ActRead: begin
                  exp_r.color = color_mem[req_tdata[239:222]][23:0];
                  exp_r.covered = color_mem[req_tdata[239:222]][24];
                  exp_r.depth = depth_mem[req_tdata[239:222]];
               end
               default: ;
            endcase
            expected_q.insert(expected_q.size(), exp_r);
         end
      end
   end
endmodule

[bench/depth_buffer_triangle_rasterizer_unit_tb.sv]
// Testbench top of the rasteriser: clock, reset, stimulus, register writes and the verdict.
module depth_buffer_triangle_rasterizer_unit_tb;
   import dbtr_pkg::*;

   localparam int WatchLimit = 2000000;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [ReqDataBits-1:0] req_tdata = '0;
   logic [1:0]             req_tuser = ActClear;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RspDataBits-1:0] rsp_tdata;
   logic                   csr_psel = 1'b0;
   logic                   csr_penable = 1'b0;
   logic                   csr_pwrite = 1'b0;
   logic [3:0]             csr_paddr = '0;
   logic [31:0]            csr_pwdata = '0;
   logic [31:0]            csr_prdata;
   logic                   csr_pready;
   int                     pending;
   int                     errors;
   int                     gap_pct = 0;
   int                     stall_pct = 0;
   int                     quiet = 0;

   always #4 clock = ~clock;

   depth_buffer_triangle_rasterizer_unit u_top (.*);

   dbtr_scoreboard u_scoreboard (.*);

   always @(posedge clock) rsp_tready <= ($urandom_range(99) >= stall_pct);

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet <= 0;
      else quiet <= quiet + 1;
      if (quiet >= WatchLimit) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   task automatic push(input logic [1:0] act, input logic [239:0] d);
      if ($urandom_range(99) < gap_pct) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < gap_pct);
      end
      req_tvalid <= 1'b1;
      req_tuser <= act;
      req_tdata <= d;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic settle();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (200) @(posedge clock);
   endtask

   task automatic csr_write(input logic [1:0] reg_id, input logic [31:0] value);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr <= {reg_id, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   function automatic logic [239:0] tri_word(input logic [16:0] x0, y0, input logic [23:0] z0,
                                             input logic [16:0] x1, y1, input logic [23:0] z1,
                                             input logic [16:0] x2, y2, input logic [23:0] z2,
                                             input logic [47:0] sh);
      return {18'd0, sh, z2, y2, x2, z1, y1, x1, z0, y0, x0};
   endfunction

   function automatic logic [239:0] read_word(input logic [17:0] idx);
      return {idx, 222'd0};
   endfunction

   function automatic logic [239:0] noise_word();
      return {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
              16'($urandom)};
   endfunction

   task automatic random_items(input int count, input int span, input int reach,
                               input bit full_coords);
      logic [16:0] bx, by;
      logic [239:0] d;
      int pick;
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(99);
         d = noise_word();
         if (pick < 70) begin
            if (!full_coords) begin
               bx = 17'($urandom_range(span * 16));
               by = 17'($urandom_range(span * 16));
               d[16:0] = bx + 17'($urandom_range(48));
               d[33:17] = by + 17'($urandom_range(48));
               d[74:58] = bx + 17'($urandom_range(48));
               d[91:75] = by + 17'($urandom_range(48));
               d[132:116] = bx + 17'($urandom_range(48));
               d[149:133] = by + 17'($urandom_range(48));
            end
            push(ActDraw, d);
         end else if (pick < 95) begin
            if ($urandom_range(9) != 0)
               d[239:222] = 18'($urandom_range(reach) * MaxWidth + $urandom_range(reach));
            push(ActRead, d);
         end else begin
            push(2'd3, d);
         end
      end
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      csr_write(RegFrameWidth, 32'd16);
      csr_write(RegFrameHeight, 32'd16);
      csr_write(RegCullBack, 32'd1);

      push(ActRead, read_word(18'd0));
      push(ActDraw, tri_word(-17'sd65536, -17'sd65536, 24'd100, 17'sd65535, -17'sd65536,
                             24'd200, -17'sd65536, 17'sd65535, 24'd300, 48'hFFFFFF_FFFFFF));
      push(ActRead, read_word(18'd0));
      push(ActRead, read_word(18'd15 * MaxWidth + 18'd15));
      push(ActDraw, tri_word(17'd0, 17'd0, 24'd0, 17'd64, 17'd0, 24'd50, 17'd0, 17'd64,
                             24'd99, 48'h80C040_FF8000));
      push(ActDraw, tri_word(17'd0, 17'd0, 24'd0, 17'd0, 17'd64, 24'd0, 17'd64, 17'd0, 24'd0,
                             48'h123456_789ABC));
      push(ActDraw, tri_word(17'd0, 17'd0, 24'd5, 17'd16, 17'd16, 24'd5, 17'd32, 17'd32, 24'd5,
                             48'hFFFFFF_FFFFFF));
      push(ActDraw, tri_word(-17'sd1000, -17'sd1000, 24'd1, -17'sd900, -17'sd1000, 24'd1,
                             -17'sd1000, -17'sd900, 24'd1, 48'h0));
      push(ActDraw, tri_word(17'd8, 17'd8, 24'hFFFFFF, 17'd200, 17'd8, 24'hFFFFFF, 17'd8,
                             17'd200, 24'hFFFFFF, 48'hFFFFFF_000000));
      push(ActDraw, tri_word(17'd8, 17'd8, 24'd0, 17'd40, 17'd8, 24'd0, 17'd8, 17'd40, 24'd0,
                             48'hFFFFFF_000000));
      push(2'd3, {240{1'b1}});
      push(ActRead, read_word(18'd17));
      push(ActRead, read_word(18'h3FFFF));
      push(ActRead, read_word(18'd1 * MaxWidth + 18'd1));
      settle();
      csr_write(RegCullBack, 32'd0);
      csr_write(RegFrameWidth, 32'd1);
      csr_write(RegFrameHeight, 32'd512);
      push(ActDraw, tri_word(17'd0, 17'd0, 24'd10, 17'd0, 17'd100, 24'd20, 17'd100, 17'd0,
                             24'd30, 48'hFF00FF_204060));
      push(ActRead, read_word(18'd3 * MaxWidth));
      settle();
      csr_write(RegFrameWidth, 32'd512);
      csr_write(RegFrameHeight, 32'd1);
      push(ActDraw, tri_word(17'd0, 17'd0, 24'd10, 17'd0, 17'd40, 24'd20, 17'd200, 17'd0,
                             24'd30, 48'h00FF00_FFFFFF));
      push(ActRead, read_word(18'd5));
      push(ActClear, '0);
      push(ActRead, read_word(18'd5));
      settle();

      csr_write(RegFrameWidth, 32'd512);
      csr_write(RegFrameHeight, 32'd512);
      csr_write(RegCullBack, 32'd1);
      gap_pct = 27;
      stall_pct = 50;
      random_items(150, 40, 45, 1'b0);
      settle();
      csr_write(RegCullBack, 32'd0);
      random_items(150, 40, 45, 1'b0);
      settle();
      csr_write(RegFrameWidth, 32'd4);
      csr_write(RegFrameHeight, 32'd4);
      gap_pct = 50;
      stall_pct = 27;
      random_items(250, 0, 4, 1'b1);
      settle();
      csr_write(RegFrameWidth, 32'd100);
      csr_write(RegFrameHeight, 32'd60);
      csr_write(RegCullBack, 32'd1);
      gap_pct = 0;
      stall_pct = 0;
      random_items(250, 110, 110, 1'b0);
      settle();

      if (errors == 0) $display("SCOREBOARD CLEAN");
      else $display("SCOREBOARD MISMATCH");
      $finish;
   end
endmodule

[files.f]
+incdir+rtl
rtl/dbtr_pkg.sv
rtl/dbtr_ram.sv
rtl/dbtr_fifo.sv
rtl/dbtr_front.sv
rtl/dbtr_back.sv
rtl/depth_buffer_triangle_rasterizer_unit.sv
rtl/dbtr_checker.sv
bench/dbtr_scoreboard.sv
bench/depth_buffer_triangle_rasterizer_unit_tb.sv
